// ===== sv/polynomial_with_derivatives_defines.svh =====
// Assertion helpers; the using scope provides clk and rst_n.
`ifndef POLYNOMIAL_WITH_DERIVATIVES_DEFINES_SVH
`define POLYNOMIAL_WITH_DERIVATIVES_DEFINES_SVH

// Same-cycle implication.
`define PWD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pwd_pkg.sv =====
package pwd_pkg;

    function automatic int fall_fact(input int k, input int d);
        int w;
        w = 1;
        for (int i = 0; i < d; i++)
        begin
            w = w * (k - i);
        end
        return w;
    endfunction

    localparam int FRAC_BITS   = 24;
    localparam int NUM_COEFS   = 8;
    localparam int NUM_DERIVS  = 5;
    localparam int TIME_W      = 27;
    localparam int COEF_W      = 32;
    localparam int OUT_W       = 48;
    localparam int REG_IDX_W   = $clog2(NUM_COEFS);
    localparam int APB_ADDR_W  = REG_IDX_W + 2;
    localparam int APB_DATA_W  = 32;

    localparam int POW_W       = FRAC_BITS + (NUM_COEFS - 1) * (TIME_W - FRAC_BITS);
    localparam int POW_LO_W    = (POW_W + 1) / 2;
    localparam int POW_HI_W    = POW_W - POW_LO_W;
    localparam int WEIGHT_W    = $clog2(fall_fact(NUM_COEFS - 1, NUM_DERIVS - 1) + 1);
    localparam int LANE_PROD_W = COEF_W + POW_W + 1;
    localparam int ACC_W       = COEF_W + POW_W + WEIGHT_W + $clog2(NUM_COEFS) + 1;

    typedef logic [TIME_W-1:0]         time_t;
    typedef logic [POW_W-1:0]          pow_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef acc_t [NUM_DERIVS-1:0]     acc_vec_t;
    typedef logic [COEF_W-1:0]         coef_t;
    typedef coef_t [NUM_COEFS-1:0]     coef_vec_t;
    typedef logic signed [OUT_W-1:0]   deriv_t;

    typedef struct packed {
        time_t    time_value;
        pow_t     power;
        acc_vec_t acc;
    } cell_word_t;

    localparam pow_t   POW_ONE = pow_t'(1) << FRAC_BITS;
    localparam deriv_t OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam deriv_t OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

endpackage

// ===== sv/pwd_time_if.sv =====
interface pwd_time_if;
    import pwd_pkg::*;

    logic  valid;
    logic  ready;
    time_t time_value;

    modport source (output valid, output time_value, input ready);
    modport sink (input valid, input time_value, output ready);
endinterface

// ===== sv/pwd_result_if.sv =====
interface pwd_result_if;
    import pwd_pkg::*;

    logic   valid;
    logic   ready;
    deriv_t position_value;
    deriv_t first_derivative;
    deriv_t second_derivative;
    deriv_t third_derivative;
    deriv_t fourth_derivative;
    logic   overflow_flag;

    modport source (
        output valid,
        output position_value,
        output first_derivative,
        output second_derivative,
        output third_derivative,
        output fourth_derivative,
        output overflow_flag,
        input  ready
    );
    modport sink (
        input  valid,
        input  position_value,
        input  first_derivative,
        input  second_derivative,
        input  third_derivative,
        input  fourth_derivative,
        input  overflow_flag,
        output ready
    );
endinterface

// ===== sv/pwd_cell.sv =====
`include "polynomial_with_derivatives_defines.svh"

module pwd_cell #(
    parameter int POWER_IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pwd_pkg::coef_vec_t  coef,
    input  logic                in_valid,
    output logic                in_ready,
    input  pwd_pkg::cell_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output pwd_pkg::cell_word_t out_word
);
    import pwd_pkg::*;

    localparam int PW_LO_PP_W = POW_LO_W + TIME_W;
    localparam int PW_HI_PP_W = POW_HI_W + TIME_W;
    localparam int PW_FULL_W  = POW_W + TIME_W;
    localparam int LO_PP_W    = COEF_W + POW_LO_W + 1;
    localparam int HI_PP_W    = COEF_W + POW_HI_W + 1;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s1_en, s2_en, s3_en;

    time_t                 s1_time_reg, s1_time_next;
    acc_vec_t              s1_acc_reg, s1_acc_next;
    logic [PW_LO_PP_W-1:0] pw_pp_lo_reg, pw_pp_lo_next;
    logic [PW_HI_PP_W-1:0] pw_pp_hi_reg, pw_pp_hi_next;
    logic [PW_FULL_W-1:0]  pw_full;

    time_t      s2_time_reg, s2_time_next;
    acc_vec_t   s2_acc_reg, s2_acc_next;
    pow_t       s2_power_reg, s2_power_next;

    acc_t       s3_acc_lane [NUM_DERIVS];
    cell_word_t s3_word_reg, s3_word_next;

    assign s3_en    = !s3_valid_reg || out_ready;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    always_comb
    begin
        s1_valid_next = s1_en ? in_valid : s1_valid_reg;
        s2_valid_next = s2_en ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_en ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // next power of time, split into two partial products
    always_comb
    begin
        s1_time_next  = in_word.time_value;
        s1_acc_next   = in_word.acc;
        pw_pp_lo_next = PW_LO_PP_W'(in_word.power[POW_LO_W-1:0])
                      * PW_LO_PP_W'(in_word.time_value);
        pw_pp_hi_next = PW_HI_PP_W'(in_word.power[POW_W-1:POW_LO_W])
                      * PW_HI_PP_W'(in_word.time_value);
        pw_full       = (PW_FULL_W'(pw_pp_hi_reg) << POW_LO_W) + PW_FULL_W'(pw_pp_lo_reg);
        s2_time_next  = s1_time_reg;
        s2_acc_next   = s1_acc_reg;
        s2_power_next = POW_W'(pw_full >> FRAC_BITS);
    end

    for (genvar d = 0; d < NUM_DERIVS; d++)
    begin : g_lane
        if (POWER_IDX + d < NUM_COEFS)
        begin : g_term
            localparam int K = POWER_IDX + d;
            localparam logic signed [ACC_W-1:0] WEIGHT = ACC_W'(fall_fact(K, d));

            logic signed [LO_PP_W-1:0]     pp_lo_reg, pp_lo_next;
            logic signed [HI_PP_W-1:0]     pp_hi_reg, pp_hi_next;
            logic signed [LANE_PROD_W-1:0] prod_reg, prod_next;
            acc_t                          term;

            assign pp_lo_next = LO_PP_W'($signed(coef[NUM_COEFS-1-K]))
                              * LO_PP_W'($signed({1'b0, in_word.power[POW_LO_W-1:0]}));
            assign pp_hi_next = HI_PP_W'($signed(coef[NUM_COEFS-1-K]))
                              * HI_PP_W'($signed({1'b0, in_word.power[POW_W-1:POW_LO_W]}));
            assign prod_next  = (LANE_PROD_W'(pp_hi_reg) <<< POW_LO_W)
                              + LANE_PROD_W'(pp_lo_reg);
            assign term       = ACC_W'(prod_reg) * WEIGHT;
            assign s3_acc_lane[d] = ACC_W'($signed(s2_acc_reg[d]) + term);

            always_ff @(posedge clk)
            begin
                if (s1_en)
                begin
                    pp_lo_reg <= pp_lo_next;
                    pp_hi_reg <= pp_hi_next;
                end
                if (s2_en)
                begin
                    prod_reg <= prod_next;
                end
            end
        end
        else
        begin : g_pass
            assign s3_acc_lane[d] = s2_acc_reg[d];
        end
    end

    always_comb
    begin
        s3_word_next.time_value = s2_time_reg;
        s3_word_next.power      = s2_power_reg;
        for (int d = 0; d < NUM_DERIVS; d++)
        begin
            s3_word_next.acc[d] = s3_acc_lane[d];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_time_reg  <= s1_time_next;
            s1_acc_reg   <= s1_acc_next;
            pw_pp_lo_reg <= pw_pp_lo_next;
            pw_pp_hi_reg <= pw_pp_hi_next;
        end
        if (s2_en)
        begin
            s2_time_reg  <= s2_time_next;
            s2_acc_reg   <= s2_acc_next;
            s2_power_reg <= s2_power_next;
        end
        if (s3_en)
        begin
            s3_word_reg <= s3_word_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_word  = s3_word_reg;

    `PWD_ASSERT_NOW(a_stall_only_full, !in_ready, s1_valid_reg && s2_valid_reg && s3_valid_reg, "cell refuses a word with a free stage")
    `PWD_ASSERT_NEXT(a_time_advances, s1_valid_reg && s2_en, s2_valid_reg && (s2_time_reg == $past(s1_time_reg)), "time lost between stages")

endmodule

// ===== sv/pwd_out_stage.sv =====
`include "polynomial_with_derivatives_defines.svh"

module pwd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pwd_pkg::acc_vec_t in_acc,
    pwd_result_if.source      result
);
    import pwd_pkg::*;

    logic   valid_reg, valid_next;
    logic   en;
    acc_t   shifted [NUM_DERIVS];
    logic   fits [NUM_DERIVS];
    deriv_t deriv_reg [NUM_DERIVS];
    deriv_t deriv_next [NUM_DERIVS];
    logic   ovf_reg, ovf_next;

    assign en       = !valid_reg || result.ready;
    assign in_ready = en;

    always_comb
    begin
        valid_next = en ? in_valid : valid_reg;
    end

    // drop the extra fraction bits, then clamp to the output range
    always_comb
    begin
        ovf_next = 1'b0;
        for (int d = 0; d < NUM_DERIVS; d++)
        begin
            shifted[d] = $signed(in_acc[d]) >>> FRAC_BITS;
            fits[d]    = (&shifted[d][ACC_W-1:OUT_W-1]) || !(|shifted[d][ACC_W-1:OUT_W-1]);
            if (fits[d])
            begin
                deriv_next[d] = shifted[d][OUT_W-1:0];
            end
            else if (shifted[d][ACC_W-1])
            begin
                deriv_next[d] = OUT_MIN;
            end
            else
            begin
                deriv_next[d] = OUT_MAX;
            end
            ovf_next = ovf_next || !fits[d];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deriv_reg <= deriv_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign result.valid             = valid_reg;
    assign result.position_value    = deriv_reg[0];
    assign result.first_derivative  = deriv_reg[1];
    assign result.second_derivative = deriv_reg[2];
    assign result.third_derivative  = deriv_reg[3];
    assign result.fourth_derivative = deriv_reg[4];
    assign result.overflow_flag     = ovf_reg;

    `PWD_ASSERT_NOW(a_flag_at_bound, result.valid && result.overflow_flag, deriv_reg[0] == OUT_MAX || deriv_reg[0] == OUT_MIN || deriv_reg[1] == OUT_MAX || deriv_reg[1] == OUT_MIN || deriv_reg[2] == OUT_MAX || deriv_reg[2] == OUT_MIN || deriv_reg[3] == OUT_MAX || deriv_reg[3] == OUT_MIN || deriv_reg[4] == OUT_MAX || deriv_reg[4] == OUT_MIN, "overflow flagged with no clamped output")
    `PWD_ASSERT_NEXT(a_word_presented, in_valid && in_ready, result.valid, "accepted sum not presented")

endmodule

// ===== sv/polynomial_with_derivatives.sv =====
// Degree-7 polynomial evaluator with its first four time derivatives.
// Load the eight Q8.24 coefficients over the APB port (register i at byte
// address 4*i, highest power first); reads return the stored value.
// Write coefficients only while no sample is in flight.
// sample: one word per time value, unsigned Q3.24.
// result: one word per sample, in order: p(t) and p'(t) to p''''(t) in
// Q24.24, each clamped to 48 bits, plus a flag set when any was clamped.
// From sample accept to result valid, a word passes eight cells
// of three stages each (split power and coefficient multipliers, then
// the weighted accumulate) and one saturating output register.
// Throughput is one sample per cycle while result.ready stays high.
// Reset clears all coefficients to zero and empties the pipeline.
// When result.ready is low, words pile up stage by stage behind the
// output register; sample.ready drops only once every stage holds a word.
module polynomial_with_derivatives (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pwd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pwd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pwd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    pwd_time_if.sink                        sample,
    pwd_result_if.source                    result
);
    import pwd_pkg::*;

    coef_vec_t              coef_reg, coef_next;
    logic                   cfg_write;
    logic [REG_IDX_W-1:0]   reg_index;

    logic       chain_valid [NUM_COEFS+1];
    logic       chain_ready [NUM_COEFS+1];
    cell_word_t chain_word [NUM_COEFS+1];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign prdata    = APB_DATA_W'(coef_reg[reg_index]);

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_write)
        begin
            coef_next[reg_index] = pwdata[COEF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign chain_valid[0] = sample.valid;
    assign sample.ready   = chain_ready[0];
    assign chain_word[0]  = '{time_value: sample.time_value, power: POW_ONE, acc: '0};

    for (genvar i = 0; i < NUM_COEFS; i++)
    begin : g_cell
        pwd_cell #(
            .POWER_IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .coef      (coef_reg),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    pwd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[NUM_COEFS]),
        .in_ready (chain_ready[NUM_COEFS]),
        .in_acc   (chain_word[NUM_COEFS].acc),
        .result   (result)
    );

endmodule

// ===== verif/tb_polynomial_with_derivatives.sv =====
module tb_polynomial_with_derivatives;
    import pwd_pkg::*;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SETTLE_WAIT  = 40;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 180;
    localparam time_t       TIME_MAX     = {TIME_W{1'b1}};
    localparam time_t       ONE_SEC      = time_t'(1) << FRAC_BITS;
    localparam coef_t       COEF_MAX     = 32'h7FFF_FFFF;
    localparam coef_t       COEF_MIN     = 32'h8000_0000;
    localparam coef_t       COEF_ONE     = coef_t'(1) << FRAC_BITS;
    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -128'sh8000_0000_0000;

    typedef struct packed {
        deriv_t [NUM_DERIVS-1:0] value;
        logic                    overflow_flag;
    } deriv_word_t;

    logic                  clk;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic  send_valid   = 1'b0;
    time_t send_time    = '0;
    logic  take_ready   = 1'b0;
    logic  recv_blocked = 1'b0;
    bit    hold_request = 1'b0;
    bit    send_idle_en = 1'b0;
    bit    recv_idle_en = 1'b0;
    int    send_gap     = 0;
    int    recv_stall   = 0;
    logic  offer_next;
    logic  take_next;

    int          result_errors = 0;
    int          config_errors = 0;
    int unsigned cycle_count   = 0;

    coef_t       coef_model [NUM_COEFS] = '{default: '0};
    coef_t       coef_plan  [NUM_COEFS];
    time_t       pending_times [$];
    deriv_word_t derivs_due [$];
    string       field_names [NUM_DERIVS] = '{"position_value", "first_derivative",
        "second_derivative", "third_derivative", "fourth_derivative"};

    pwd_time_if   sample_ch ();
    pwd_result_if result_ch ();

    assign sample_ch.valid      = send_valid;
    assign sample_ch.time_value = send_time;
    assign result_ch.ready      = take_ready;

    polynomial_with_derivatives u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .result  (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic deriv_word_t eval_poly_derivs(input time_t t);
        logic [127:0]        wide;
        logic [63:0]         powers [NUM_COEFS];
        logic signed [63:0]  coef_ext;
        logic signed [63:0]  weighted;
        logic signed [127:0] acc;
        logic signed [127:0] term;
        logic signed [127:0] scaled;
        int                  w;
        deriv_word_t         r;
        powers[0] = 64'd1 << FRAC_BITS;
        for (int k = 1; k < NUM_COEFS; k++)
        begin
            wide = {64'd0, powers[k-1]} * {{(128 - TIME_W){1'b0}}, t};
            if (wide[127:64+FRAC_BITS] != 0)
                powers[k] = '1;
            else
                powers[k] = wide[FRAC_BITS +: 64];
        end
        r.overflow_flag = 1'b0;
        for (int d = 0; d < NUM_DERIVS; d++)
        begin
            acc = '0;
            for (int k = d; k < NUM_COEFS; k++)
            begin
                coef_ext = {{32{coef_model[NUM_COEFS-1-k][31]}}, coef_model[NUM_COEFS-1-k]};
                w = 1;
                for (int j = 0; j < d; j++)
                    w = w * (k - j);
                weighted = coef_ext * w;
                term = $signed({{64{weighted[63]}}, weighted}) * $signed({64'd0, powers[k-d]});
                acc = acc + term;
            end
            scaled = acc >>> FRAC_BITS;
            if (scaled > SAT_HI)
            begin
                r.value[d] = OUT_MAX;
                r.overflow_flag = 1'b1;
            end
            else if (scaled < SAT_LO)
            begin
                r.value[d] = OUT_MIN;
                r.overflow_flag = 1'b1;
            end
            else
            begin
                r.value[d] = scaled[OUT_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic time_t pick_time();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return TIME_MAX;
            2: return time_t'($urandom_range(0, 1 << FRAC_BITS));
            3: return time_t'(1) << $urandom_range(0, TIME_W - 1);
            4: return time_t'(ONE_SEC * $urandom_range(1, 7));
            default: return time_t'($urandom);
        endcase
    endfunction

    function automatic coef_t pick_coef(input bit small_only);
        coef_t mag;
        mag = coef_t'($urandom_range(0, 1 << 21));
        if (small_only)
            return $urandom_range(0, 1) ? mag : -mag;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COEF_MAX;
            2: return COEF_MIN;
            3: return $urandom_range(0, 1) ? mag : -mag;
            4: return $urandom_range(0, 1) ? COEF_ONE : -COEF_ONE;
            default: return coef_t'($urandom);
        endcase
    endfunction

    task automatic check_result();
        deriv_word_t want;
        deriv_word_t got;
        got.value[0]    = result_ch.position_value;
        got.value[1]    = result_ch.first_derivative;
        got.value[2]    = result_ch.second_derivative;
        got.value[3]    = result_ch.third_derivative;
        got.value[4]    = result_ch.fourth_derivative;
        got.overflow_flag = result_ch.overflow_flag;
        if (derivs_due.size() == 0)
        begin
            if (result_errors + config_errors < 10)
                $display("result word with nothing pending: position %h", got.value[0]);
            result_errors++;
            return;
        end
        want = derivs_due.pop_front();
        for (int d = 0; d < NUM_DERIVS; d++)
        begin
            if (got.value[d] !== want.value[d])
            begin
                if (result_errors + config_errors < 10)
                    $display("%s mismatch: expected %h, got %h",
                        field_names[d], want.value[d], got.value[d]);
                result_errors++;
            end
        end
        if (got.overflow_flag !== want.overflow_flag)
        begin
            if (result_errors + config_errors < 10)
                $display("overflow_flag mismatch: expected %b, got %b",
                    want.overflow_flag, got.overflow_flag);
            result_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        offer_next = send_valid;
        if (send_valid && sample_ch.ready)
        begin
            derivs_due.push_back(eval_poly_derivs(send_time));
            offer_next = 1'b0;
            send_gap = send_idle_en ? pick_gap() : 0;
        end
        if (!offer_next && rst_n)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
            end
            else if (pending_times.size() != 0)
            begin
                send_time <= pending_times.pop_front();
                offer_next = 1'b1;
            end
        end
        send_valid <= offer_next;
    end

    always @(posedge clk)
    begin
        if (result_ch.valid && take_ready)
            check_result();
        if (recv_blocked)
        begin
            take_next = 1'b0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall = recv_stall - 1;
            take_next = 1'b0;
        end
        else if (recv_idle_en && $urandom_range(0, 3) == 0)
        begin
            recv_stall = pick_gap();
            take_next = (recv_stall == 0);
        end
        else
        begin
            take_next = 1'b1;
        end
        take_ready <= rst_n && take_next;
    end

    // hold off the result side while the sample side keeps pushing
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        recv_blocked <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_blocked <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_polynomial_with_derivatives NOT OK");
            $finish;
        end
    end

    task automatic apb_access(input bit wr, input int idx, input coef_t data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (wr)
        begin
            coef_model[idx] = data;
        end
        else if (prdata !== coef_model[idx])
        begin
            if (result_errors + config_errors < 10)
                $display("coef_pow%0d readback: expected %h, got %h",
                    NUM_COEFS - 1 - idx, coef_model[idx], prdata);
            config_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_coefs();
        for (int i = 0; i < NUM_COEFS; i++)
            apb_access(1'b1, i, coef_plan[i]);
        for (int i = 0; i < NUM_COEFS; i++)
            apb_access(1'b0, i, '0);
    endtask

    // drop to idle: every word sent, every result back, pipeline settled
    task automatic drain_pipeline();
        @(negedge clk);
        while (pending_times.size() != 0 || send_valid || derivs_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        pending_times.push_back('0);
        pending_times.push_back(TIME_MAX);
        drain_pipeline();

        for (int i = 0; i < NUM_COEFS; i++)
            coef_plan[i] = COEF_MAX;
        load_coefs();
        pending_times.push_back('0);
        pending_times.push_back(time_t'(1));
        pending_times.push_back(ONE_SEC);
        pending_times.push_back(TIME_MAX);
        pending_times.push_back(27'h2AA_AAAA);
        drain_pipeline();

        for (int i = 0; i < NUM_COEFS; i++)
            coef_plan[i] = COEF_MIN;
        load_coefs();
        pending_times.push_back(TIME_MAX);
        pending_times.push_back('0);
        pending_times.push_back(ONE_SEC);
        drain_pipeline();

        for (int i = 0; i < NUM_COEFS; i++)
            coef_plan[i] = (i % 2) ? COEF_MIN : COEF_MAX;
        load_coefs();
        pending_times.push_back(TIME_MAX);
        pending_times.push_back(ONE_SEC);
        drain_pipeline();

        for (int i = 0; i < NUM_COEFS; i++)
            coef_plan[i] = COEF_ONE;
        load_coefs();
        pending_times.push_back('0);
        pending_times.push_back(ONE_SEC);
        pending_times.push_back(time_t'(ONE_SEC * 2));
        pending_times.push_back(TIME_MAX);
        pending_times.push_back(27'h555_5555);
        pending_times.push_back(27'h0FF_FFFF);
        drain_pipeline();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
                coef_plan[i] = pick_coef(ph == 2 || ph == 6);
            load_coefs();
            send_idle_en = (ph != 0 && ph != 3);
            recv_idle_en = (ph != 0 && ph != 4);
            if (ph == 3)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_times.push_back(pick_time());
            drain_pipeline();
        end

        if (result_errors == 0 && config_errors == 0)
            $display("tb_polynomial_with_derivatives OK");
        else
            $display("tb_polynomial_with_derivatives NOT OK");
        $finish;
    end

endmodule
